### rtl/swept_aabb_collision_assert.svh
// Assertion macros for the swept box collision block
`ifndef SWEPT_AABB_COLLISION_ASSERT_SVH
`define SWEPT_AABB_COLLISION_ASSERT_SVH

// implication check, sampled on clk, off while in reset
`define SAC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// condition that must never be seen
`define SAC_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

### rtl/sac_pkg.sv
// Shared constants and types of the swept box collision block
`default_nettype none
package sac_pkg;
	localparam int CW      = 32;
	localparam int FB      = 16;
	localparam int TIN_W   = FB + 8;
	localparam int TOUT_W  = FB + 1;
	localparam int NUM_W   = CW + 3;
	localparam int SNUM_W  = NUM_W + FB;
	localparam int HI_W    = SNUM_W - CW;
	localparam int DIV_LAT = CW + 2;
	localparam int TOT_LAT = DIV_LAT + 6;
	localparam int PW      = CW + TIN_W + 1;
	localparam int MW      = CW + TOUT_W + 1;

	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam logic signed [1:0] NRM_POS  = 2'sb01;
	localparam logic signed [1:0] NRM_NEG  = 2'sb11;
	localparam logic signed [1:0] NRM_ZERO = 2'sb00;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic   miss;
		logic   zx;
		logic   zy;
		logic   sx0;
		logic   sx1;
		logic   sy0;
		logic   sy1;
		logic signed [CW:0] ox;
		logic signed [CW:0] oy;
		coord_t dx;
		coord_t dy;
	} side_t;
endpackage
`default_nettype wire

### rtl/sac_div.sv
// Pipelined signed divider, one quotient bit per stage, result clamped to coordinate range
`default_nettype none
module sac_div (
	input  wire logic                              clk,
	input  wire logic signed [sac_pkg::SNUM_W-1:0] num,
	input  wire logic signed [sac_pkg::CW-1:0]     den,
	output logic signed [sac_pkg::CW-1:0]          quo
);
	import sac_pkg::*;

	logic [SNUM_W-1:0] nmag;
	logic [CW-1:0]     dmag;
	logic [HI_W-1:0]   hi;

	logic [CW-1:0] rem_s [0:CW];
	logic [CW-1:0] low_s [0:CW];
	logic [CW-1:0] q_s   [0:CW];
	logic [CW-1:0] d_s   [0:CW];
	logic          neg_s [0:CW];
	logic          ovf_s [0:CW];

	assign nmag = num[SNUM_W-1] ? SNUM_W'(-num) : SNUM_W'(num);
	assign dmag = den[CW-1] ? CW'(-den) : CW'(den);
	assign hi   = nmag[SNUM_W-1:CW];

	always_ff @(posedge clk) begin
		ovf_s[0] <= ({{(CW-HI_W){1'b0}}, hi} >= dmag);
		rem_s[0] <= ({{(CW-HI_W){1'b0}}, hi} >= dmag) ? '0 : {{(CW-HI_W){1'b0}}, hi};
		low_s[0] <= nmag[CW-1:0];
		q_s[0]   <= '0;
		d_s[0]   <= dmag;
		neg_s[0] <= num[SNUM_W-1] ^ den[CW-1];
	end

	for (genvar i = 0; i < CW; i++) begin : g_step
		logic [CW:0] trial;
		logic        ge;
		assign trial = {rem_s[i], low_s[i][CW-1]};
		assign ge    = trial >= {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? CW'(trial - {1'b0, d_s[i]}) : trial[CW-1:0];
			low_s[i+1] <= {low_s[i][CW-2:0], 1'b0};
			q_s[i+1]   <= {q_s[i][CW-2:0], ge};
			d_s[i+1]   <= d_s[i];
			neg_s[i+1] <= neg_s[i];
			ovf_s[i+1] <= ovf_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (!neg_s[CW]) begin
			quo <= (ovf_s[CW] || q_s[CW][CW-1]) ? C_MAX : $signed(q_s[CW]);
		end else begin
			quo <= (ovf_s[CW] || (q_s[CW][CW-1] && |q_s[CW][CW-2:0])) ? C_MIN
				: $signed(CW'(-q_s[CW]));
		end
	end
endmodule
`default_nettype wire

### rtl/swept_aabb_collision.sv
// Top level of the swept box collision pipeline
// Usage:
//  Raise start with one word of mover and target fields; it is taken at that
//  clock edge. busy is held low: a new word may be taken on every cycle.
//  Each word gives one result word, in order; done rises with the result word.
//  Throughput is one word per cycle; a word passes through the four pipelined
//  slab dividers (34 register stages, 32 of them one quotient bit each) plus
//  six stages of offset, clamp, slab compare, multiply and contact arithmetic.
//  On a miss hit, entry_time, contact_x/y and normal_x/y are all zero.
//  Reset clears every valid bit at once; words in flight are dropped.
//  The receiver cannot hold results off, so nothing ever stalls.
`default_nettype none
module swept_aabb_collision (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [sac_pkg::CW-1:0]     mover_pos_x,
	input  wire logic signed [sac_pkg::CW-1:0]     mover_pos_y,
	input  wire logic [sac_pkg::CW-2:0]            mover_width,
	input  wire logic [sac_pkg::CW-2:0]            mover_height,
	input  wire logic signed [sac_pkg::CW-1:0]     mover_vel_x,
	input  wire logic signed [sac_pkg::CW-1:0]     mover_vel_y,
	input  wire logic signed [sac_pkg::CW-1:0]     target_pos_x,
	input  wire logic signed [sac_pkg::CW-1:0]     target_pos_y,
	input  wire logic [sac_pkg::CW-2:0]            target_width,
	input  wire logic [sac_pkg::CW-2:0]            target_height,
	input  wire logic [sac_pkg::TIN_W-1:0]         elapsed_time,
	output logic                                   done,
	output logic                                   hit,
	output logic [sac_pkg::TOUT_W-1:0]             entry_time,
	output logic signed [sac_pkg::CW-1:0]          contact_x,
	output logic signed [sac_pkg::CW-1:0]          contact_y,
	output logic signed [1:0]                      normal_x,
	output logic signed [1:0]                      normal_y
);
	import sac_pkg::*;

	// stage 1: offsets, numerators, displacement products
	logic signed [NUM_W-1:0] px, py, tx, ty, hw, hh, mw, mh, tw, th;
	logic signed [NUM_W-1:0] ox_c, oy_c, ex_c, ey_c;
	logic                    valid_s1, vzero_s1;
	logic signed [NUM_W-1:0] nx0_s1, nx1_s1, ny0_s1, ny1_s1, ox_s1, oy_s1;
	logic signed [PW-1:0]    prx_s1, pry_s1;

	assign busy = 1'b0;

	assign px = NUM_W'(mover_pos_x);
	assign py = NUM_W'(mover_pos_y);
	assign tx = NUM_W'(target_pos_x);
	assign ty = NUM_W'(target_pos_y);
	assign mw = $signed({4'b0, mover_width});
	assign mh = $signed({4'b0, mover_height});
	assign tw = $signed({4'b0, target_width});
	assign th = $signed({4'b0, target_height});
	assign hw = $signed({5'b0, mover_width[CW-2:1]});
	assign hh = $signed({5'b0, mover_height[CW-2:1]});
	assign ox_c = px + hw;
	assign oy_c = py + hh;
	assign ex_c = tx - hw;
	assign ey_c = ty - hh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start;
	end

	always_ff @(posedge clk) begin
		vzero_s1 <= (mover_vel_x == '0) && (mover_vel_y == '0);
		ox_s1    <= ox_c;
		oy_s1    <= oy_c;
		nx0_s1   <= ex_c - ox_c;
		ny0_s1   <= ey_c - oy_c;
		nx1_s1   <= ex_c + tw + mw - ox_c;
		ny1_s1   <= ey_c + th + mh - oy_c;
		prx_s1   <= mover_vel_x * $signed({1'b0, elapsed_time});
		pry_s1   <= mover_vel_y * $signed({1'b0, elapsed_time});
	end

	// stage 2: displacement clamp
	logic signed [PW-1:0]    shx, shy;
	logic                    valid_s2, vzero_s2;
	logic signed [NUM_W-1:0] nx0_s2, nx1_s2, ny0_s2, ny1_s2, ox_s2, oy_s2;
	coord_t                  dx_s2, dy_s2;

	assign shx = prx_s1 >>> FB;
	assign shy = pry_s1 >>> FB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (shx > PW'(C_MAX)) dx_s2 <= C_MAX;
		else if (shx < PW'(C_MIN)) dx_s2 <= C_MIN;
		else dx_s2 <= shx[CW-1:0];
		if (shy > PW'(C_MAX)) dy_s2 <= C_MAX;
		else if (shy < PW'(C_MIN)) dy_s2 <= C_MIN;
		else dy_s2 <= shy[CW-1:0];
		vzero_s2 <= vzero_s1;
		nx0_s2   <= nx0_s1;
		nx1_s2   <= nx1_s1;
		ny0_s2   <= ny0_s1;
		ny1_s2   <= ny1_s1;
		ox_s2    <= ox_s1;
		oy_s2    <= oy_s1;
	end

	// slab dividers with matching side line
	side_t  side_in;
	side_t  side_q [0:DIV_LAT-1];
	logic   vld_q  [0:DIV_LAT-1];
	coord_t qx0, qx1, qy0, qy1;

	always_comb begin
		side_in.zx  = (dx_s2 == '0);
		side_in.zy  = (dy_s2 == '0);
		side_in.miss = vzero_s2
			|| (side_in.zx && ((nx0_s2 == '0) || (nx1_s2 == '0)))
			|| (side_in.zy && ((ny0_s2 == '0) || (ny1_s2 == '0)));
		side_in.sx0 = nx0_s2[NUM_W-1];
		side_in.sx1 = nx1_s2[NUM_W-1];
		side_in.sy0 = ny0_s2[NUM_W-1];
		side_in.sy1 = ny1_s2[NUM_W-1];
		side_in.ox  = ox_s2[CW:0];
		side_in.oy  = oy_s2[CW:0];
		side_in.dx  = dx_s2;
		side_in.dy  = dy_s2;
	end

	sac_div u_div_x0 (.clk(clk), .num($signed({nx0_s2, {FB{1'b0}}})), .den(dx_s2), .quo(qx0));
	sac_div u_div_x1 (.clk(clk), .num($signed({nx1_s2, {FB{1'b0}}})), .den(dx_s2), .quo(qx1));
	sac_div u_div_y0 (.clk(clk), .num($signed({ny0_s2, {FB{1'b0}}})), .den(dy_s2), .quo(qy0));
	sac_div u_div_y1 (.clk(clk), .num($signed({ny1_s2, {FB{1'b0}}})), .den(dy_s2), .quo(qy1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= valid_s2;
			for (int i = 1; i < DIV_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int i = 1; i < DIV_LAT; i++) side_q[i] <= side_q[i-1];
	end

	// stage 3: infinite slabs and ordering
	side_t  sd;
	coord_t ax0, ax1, ay0, ay1;
	logic   valid_s3, miss_s3;
	coord_t tnx_s3, tfx_s3, tny_s3, tfy_s3, dx_s3, dy_s3;
	logic signed [CW:0] ox_s3, oy_s3;

	assign sd  = side_q[DIV_LAT-1];
	assign ax0 = sd.zx ? (sd.sx0 ? -C_MAX : C_MAX) : qx0;
	assign ax1 = sd.zx ? (sd.sx1 ? -C_MAX : C_MAX) : qx1;
	assign ay0 = sd.zy ? (sd.sy0 ? -C_MAX : C_MAX) : qy0;
	assign ay1 = sd.zy ? (sd.sy1 ? -C_MAX : C_MAX) : qy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= vld_q[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		tnx_s3  <= (ax0 > ax1) ? ax1 : ax0;
		tfx_s3  <= (ax0 > ax1) ? ax0 : ax1;
		tny_s3  <= (ay0 > ay1) ? ay1 : ay0;
		tfy_s3  <= (ay0 > ay1) ? ay0 : ay1;
		miss_s3 <= sd.miss;
		ox_s3   <= sd.ox;
		oy_s3   <= sd.oy;
		dx_s3   <= sd.dx;
		dy_s3   <= sd.dy;
	end

	// stage 4: entry and exit tests, normal
	coord_t tnear, tfar;
	logic   hit_c;
	logic   valid_s4, hit_s4;
	logic [TOUT_W-1:0]  tn_s4;
	logic signed [1:0]  nx_s4, ny_s4;
	coord_t             dx_s4, dy_s4;
	logic signed [CW:0] ox_s4, oy_s4;

	assign tnear = (tnx_s3 > tny_s3) ? tnx_s3 : tny_s3;
	assign tfar  = (tfx_s3 < tfy_s3) ? tfx_s3 : tfy_s3;
	assign hit_c = !miss_s3 && !(tnx_s3 > tfy_s3) && !(tny_s3 > tfx_s3)
		&& !tfar[CW-1] && !tnear[CW-1] && (tnear <= (coord_t'(1) <<< FB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		hit_s4 <= hit_c;
		tn_s4  <= tnear[TOUT_W-1:0];
		nx_s4  <= (tnx_s3 > tny_s3) ? (dx_s3[CW-1] ? NRM_POS : NRM_NEG) : NRM_ZERO;
		ny_s4  <= (tnx_s3 < tny_s3) ? (dy_s3[CW-1] ? NRM_POS : NRM_NEG) : NRM_ZERO;
		dx_s4  <= dx_s3;
		dy_s4  <= dy_s3;
		ox_s4  <= ox_s3;
		oy_s4  <= oy_s3;
	end

	// stage 5: travel products
	logic               valid_s5, hit_s5;
	logic [TOUT_W-1:0]  tn_s5;
	logic signed [1:0]  nx_s5, ny_s5;
	logic signed [MW-1:0] mx_s5, my_s5;
	logic signed [CW:0] ox_s5, oy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		hit_s5 <= hit_s4;
		tn_s5  <= tn_s4;
		nx_s5  <= nx_s4;
		ny_s5  <= ny_s4;
		mx_s5  <= $signed({1'b0, tn_s4}) * dx_s4;
		my_s5  <= $signed({1'b0, tn_s4}) * dy_s4;
		ox_s5  <= ox_s4;
		oy_s5  <= oy_s4;
	end

	// stage 6: contact point and output word
	logic signed [MW:0] cx, cy;
	logic               done_q, hit_q;
	logic [TOUT_W-1:0]  time_q;
	coord_t             cx_q, cy_q;
	logic signed [1:0]  nx_q, ny_q;

	assign cx = (MW+1)'(ox_s5) + (MW+1)'(mx_s5 >>> FB);
	assign cy = (MW+1)'(oy_s5) + (MW+1)'(my_s5 >>> FB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= valid_s5;
	end

	always_ff @(posedge clk) begin
		hit_q  <= hit_s5;
		time_q <= hit_s5 ? tn_s5 : '0;
		nx_q   <= hit_s5 ? nx_s5 : NRM_ZERO;
		ny_q   <= hit_s5 ? ny_s5 : NRM_ZERO;
		if (!hit_s5) cx_q <= '0;
		else if (cx > (MW+1)'(C_MAX)) cx_q <= C_MAX;
		else if (cx < (MW+1)'(C_MIN)) cx_q <= C_MIN;
		else cx_q <= cx[CW-1:0];
		if (!hit_s5) cy_q <= '0;
		else if (cy > (MW+1)'(C_MAX)) cy_q <= C_MAX;
		else if (cy < (MW+1)'(C_MIN)) cy_q <= C_MIN;
		else cy_q <= cy[CW-1:0];
	end

	assign done         = done_q;
	assign hit          = done_q & hit_q;
	assign entry_time   = time_q;
	assign contact_x    = cx_q;
	assign contact_y    = cy_q;
	assign normal_x     = nx_q;
	assign normal_y     = ny_q;
endmodule
`default_nettype wire

### rtl/sac_chk.sv
// Port checker for the swept box collision block, bound to the top level
`default_nettype none
`include "swept_aabb_collision_assert.svh"
module sac_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          done,
	input wire logic                          hit,
	input wire logic [sac_pkg::TOUT_W-1:0]    entry_time,
	input wire logic signed [sac_pkg::CW-1:0] contact_x,
	input wire logic signed [sac_pkg::CW-1:0] contact_y,
	input wire logic signed [1:0]             normal_x,
	input wire logic signed [1:0]             normal_y
);
	import sac_pkg::*;

	logic word_zero;

	assign word_zero = entry_time == '0 && contact_x == '0 && contact_y == '0
		&& normal_x == NRM_ZERO && normal_y == NRM_ZERO;

	`SAC_ASSERT_IMPL(a_done_latency, done, $past(start, TOT_LAT))
	`SAC_ASSERT_IMPL(a_miss_zero, done && !hit, word_zero)
	`SAC_ASSERT_IMPL(a_time_range, done && hit, entry_time <= (TOUT_W'(1) << FB))
	`SAC_ASSERT_NEVER(a_two_normals, done && normal_x != NRM_ZERO && normal_y != NRM_ZERO)
endmodule

bind swept_aabb_collision sac_chk u_sac_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .done(done), .hit(hit),
	.entry_time(entry_time), .contact_x(contact_x), .contact_y(contact_y),
	.normal_x(normal_x), .normal_y(normal_y)
);
`default_nettype wire

### tb/sv/swept_aabb_collision_tb.sv
// Self-checking testbench for the swept box collision pipeline
`timescale 1ns / 100ps
`default_nettype none
module swept_aabb_collision_tb;
	import sac_pkg::*;

	localparam longint BIG = 64'sh7fffffffffffffff;
	localparam longint CMAX = 64'sh7fffffff;
	localparam longint CMIN = -64'sh80000000;
	localparam int N_RAND = 1200;

	typedef struct {
		logic signed [CW-1:0] px, py, vx, vy, tx, ty;
		logic [CW-2:0] mw, mh, tw, th;
		logic [TIN_W-1:0] dt;
	} sweep_in_t;

	typedef struct packed {
		logic hit;
		logic [TOUT_W-1:0] t;
		logic signed [CW-1:0] cx, cy;
		logic signed [1:0] nx, ny;
	} contact_t;

	function automatic longint clampc(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic longint sadd(longint a, longint b);
		if (b > 0 && a > BIG - b) return BIG;
		if (b < 0 && a < -BIG - b) return -BIG;
		return a + b;
	endfunction

	function automatic longint sneg(longint a);
		if (a < -BIG) return BIG;
		return -a;
	endfunction

	function automatic longint smul(longint a, longint b);
		logic [127:0] p;
		longint r;
		p = (a < 0 ? -128'(a) : 128'(a)) * (b < 0 ? -128'(b) : 128'(b));
		r = (p > 128'(BIG)) ? BIG : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint fshr(longint v);
		return v >>> FB;
	endfunction

	function automatic longint sshl(longint a);
		longint lim;
		lim = BIG >>> FB;
		if (a > lim) return BIG;
		if (a < -lim) return -BIG;
		return a <<< FB;
	endfunction

	function automatic bit slab(longint num, longint d, output longint t);
		t = 0;
		if (d == 0) begin
			if (num == 0) return 0;
			t = num > 0 ? CMAX : -CMAX;
			return 1;
		end
		t = clampc(sshl(num) / d);
		return 1;
	endfunction

	function automatic contact_t sweep_contact(sweep_in_t s);
		contact_t r;
		longint hw, hh, dx, dy, ox, oy, ex, ey, nx0, ny0, nx1, ny1;
		longint tnx, tny, tfx, tfy, tmp, tn, tf;
		r = '{default: 0};
		if (s.vx == 0 && s.vy == 0) return r;
		hw = longint'(s.mw) >> 1;
		hh = longint'(s.mh) >> 1;
		dx = clampc(fshr(smul(longint'(s.vx), longint'(s.dt))));
		dy = clampc(fshr(smul(longint'(s.vy), longint'(s.dt))));
		ox = sadd(longint'(s.px), hw);
		oy = sadd(longint'(s.py), hh);
		ex = sadd(longint'(s.tx), -hw);
		ey = sadd(longint'(s.ty), -hh);
		nx0 = sadd(ex, sneg(ox));
		ny0 = sadd(ey, sneg(oy));
		nx1 = sadd(sadd(ex, sadd(longint'(s.tw), longint'(s.mw))), sneg(ox));
		ny1 = sadd(sadd(ey, sadd(longint'(s.th), longint'(s.mh))), sneg(oy));
		if (!slab(nx1, dx, tfx) || !slab(ny1, dy, tfy)) return r;
		if (!slab(nx0, dx, tnx) || !slab(ny0, dy, tny)) return r;
		if (tnx > tfx) begin tmp = tnx; tnx = tfx; tfx = tmp; end
		if (tny > tfy) begin tmp = tny; tny = tfy; tfy = tmp; end
		if (tnx > tfy || tny > tfx) return r;
		tn = tnx > tny ? tnx : tny;
		tf = tfx < tfy ? tfx : tfy;
		if (tf < 0) return r;
		if (tn < 0 || tn > (64'sd1 << FB)) return r;
		if (tnx > tny) r.nx = dx < 0 ? NRM_POS : NRM_NEG;
		else if (tnx < tny) r.ny = dy < 0 ? NRM_POS : NRM_NEG;
		r.hit = 1;
		r.t = tn[TOUT_W-1:0];
		r.cx = CW'(clampc(sadd(ox, fshr(smul(tn, dx)))));
		r.cy = CW'(clampc(sadd(oy, fshr(smul(tn, dy)))));
		return r;
	endfunction

	class contact_board;
		contact_t pending[$];
		int errors, checked, hits;
		function void note_word(sweep_in_t s);
			pending.push_back(sweep_contact(s));
		endfunction
		function void check_result(contact_t a);
			contact_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word");
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a.hit) hits++;
			if (a != e) begin
				errors++;
				if (errors <= 10)
					$display("exp h%0b t%0d x%0d y%0d n%0d,%0d got h%0b t%0d x%0d y%0d n%0d,%0d",
						e.hit, e.t, e.cx, e.cy, e.nx, e.ny,
						a.hit, a.t, a.cx, a.cy, a.nx, a.ny);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0;
	logic busy, done, hit;
	logic signed [CW-1:0] px, py, vx, vy, tx, ty, cx, cy;
	logic [CW-2:0] mw, mh, tw, th;
	logic [TIN_W-1:0] dt;
	logic [TOUT_W-1:0] ct;
	logic signed [1:0] nx, ny;
	contact_board board = new();

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	swept_aabb_collision dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mover_pos_x(px), .mover_pos_y(py), .mover_width(mw), .mover_height(mh),
		.mover_vel_x(vx), .mover_vel_y(vy), .target_pos_x(tx), .target_pos_y(ty),
		.target_width(tw), .target_height(th), .elapsed_time(dt),
		.done(done), .hit(hit), .entry_time(ct), .contact_x(cx), .contact_y(cy),
		.normal_x(nx), .normal_y(ny)
	);

	initial begin
		{px, py, vx, vy, tx, ty, mw, mh, tw, th, dt} = '0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_word('{px: px, py: py, vx: vx, vy: vy, tx: tx, ty: ty,
				mw: mw, mh: mh, tw: tw, th: th, dt: dt});
		if (arst_n && done)
			board.check_result('{hit: hit, t: ct, cx: cx, cy: cy, nx: nx, ny: ny});
	end

	// one word; start stays high while the burst goes on
	task automatic send_word(sweep_in_t s, bit more);
		px <= s.px; py <= s.py; vx <= s.vx; vy <= s.vy; tx <= s.tx; ty <= s.ty;
		mw <= s.mw; mh <= s.mh; tw <= s.tw; th <= s.th; dt <= s.dt;
		start <= 1;
		do @(posedge clk); while (busy);
		if (!more) start <= 0;
	endtask

	function automatic sweep_in_t wild_word();
		sweep_in_t s;
		s.px = $urandom; s.py = $urandom; s.vx = $urandom; s.vy = $urandom;
		s.tx = $urandom; s.ty = $urandom;
		s.mw = (CW-1)'($urandom); s.mh = (CW-1)'($urandom);
		s.tw = (CW-1)'($urandom); s.th = (CW-1)'($urandom);
		s.dt = TIN_W'($urandom);
		return s;
	endfunction

	// small scene where a hit is likely
	function automatic sweep_in_t scene_word();
		sweep_in_t s;
		s.px = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
		s.py = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
		s.mw = (CW-1)'($urandom_range(0, 8 << 16));
		s.mh = (CW-1)'($urandom_range(0, 8 << 16));
		s.tx = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
		s.ty = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
		s.tw = (CW-1)'($urandom_range(0, 16 << 16));
		s.th = (CW-1)'($urandom_range(0, 16 << 16));
		s.vx = ($urandom_range(0, 4) == 0) ? 0 :
			$signed($urandom_range(0, 80 << 16)) - (40 << 16);
		s.vy = ($urandom_range(0, 4) == 0) ? 0 :
			$signed($urandom_range(0, 80 << 16)) - (40 << 16);
		s.dt = TIN_W'($urandom_range(0, 3 << 16));
		if ($urandom_range(0, 5) == 0) s.vy = s.vx;
		return s;
	endfunction

	initial begin
		sweep_in_t s, d[$];
		int n, burst;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		s = '{px: -(10 << 16), py: 0, mw: 2 << 16, mh: 2 << 16, vx: 20 << 16, vy: 0,
			tx: 0, ty: -(1 << 16), tw: 4 << 16, th: 4 << 16, dt: 1 << 16};
		d.push_back(s);
		s.vx = -(20 << 16); s.px = 10 << 16; d.push_back(s);
		s.vx = 0; d.push_back(s);
		s.vx = 0; s.vy = 0; d.push_back(s);
		s.vy = 20 << 16; s.px = 0; s.py = -(10 << 16); d.push_back(s);
		s.vy = -(20 << 16); s.py = 10 << 16; d.push_back(s);
		s.px = -(10 << 16); s.py = -(10 << 16); s.vx = 20 << 16; s.vy = 20 << 16;
		s.tx = 0; s.ty = 0; d.push_back(s);
		s.dt = 0; d.push_back(s);
		s.dt = '1; d.push_back(s);
		s = '{px: 0, py: 0, mw: 0, mh: 0, vx: 1 << 16, vy: 0, tx: 0, ty: 0,
			tw: 0, th: 0, dt: 1 << 16};
		d.push_back(s);
		s = '{px: C_MIN, py: C_MAX, mw: '1, mh: '1, vx: C_MIN, vy: C_MAX,
			tx: C_MAX, ty: C_MIN, tw: '1, th: '1, dt: '1};
		d.push_back(s);
		s.vx = C_MAX; s.vy = C_MIN; s.px = C_MAX; s.py = C_MIN; d.push_back(s);
		s = '{default: 0}; s.vx = -1; s.vy = -1; s.dt = '1; d.push_back(s);
		foreach (d[i]) send_word(d[i], i != d.size() - 1);
		n = 0;
		while (n < N_RAND) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && n < N_RAND; i++, n++)
				send_word(($urandom_range(0, 9) < 8) ? scene_word() : wild_word(),
					i != burst - 1 && n != N_RAND - 1);
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		while (board.pending.size() != 0) @(posedge clk);
		repeat (TOT_LAT + 10) @(posedge clk);
		$display("checked %0d result words, %0d of them hits", board.checked, board.hits);
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
